// ----- hdl/quoted_argument_splitter_defines.svh -----
// Assertion macros shared by the argument splitter RTL.
`ifndef QUOTED_ARGUMENT_SPLITTER_DEFINES_SVH
`define QUOTED_ARGUMENT_SPLITTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define QAS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("quoted_argument_splitter: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define QAS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("quoted_argument_splitter: next-cycle check failed");

`endif

// ----- hdl/qas_pkg.sv -----
// Package with constants and types of the quoted argument splitter.
`default_nettype none
package qas_pkg;

  // Field and register widths.
  localparam int BYTE_W     = 8;
  localparam int ARGS_W     = 13;
  localparam int LEN_W      = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Running length saturates at the top of its register.
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DELIMITER_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIMITER_CHAR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ARGS_PER_BATCH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LIMIT       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NO_RUN_WHEN_EMPTY  = 3'd5;

  // Register reset values.
  localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd10;
  localparam logic [LEN_W-1:0]  LIMIT_RESET = 18'd131072;

  // Characters with a meaning to the parser.
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BSLASH  = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_SQUOTE  = 8'h27;
  localparam logic [BYTE_W-1:0] CH_DQUOTE  = 8'h22;

  // One result transaction.
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              item_end;
    logic              batch_end;
    logic              stream_done;
    logic              run_empty;
  } result_t;

endpackage
`default_nettype wire

// ----- hdl/qas_intf.sv -----
// Channel interfaces of the quoted argument splitter.
`default_nettype none

// Input byte channel.
interface qas_byte_if;
  logic                         valid;
  logic                         ready;
  logic [qas_pkg::BYTE_W-1:0]   in_byte;
  logic                         end_of_input;
  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// Result channel.
interface qas_token_if;
  logic                         valid;
  logic                         ready;
  logic [qas_pkg::BYTE_W-1:0]   out_byte;
  logic                         byte_valid;
  logic                         item_end;
  logic                         batch_end;
  logic                         stream_done;
  logic                         run_empty;
  modport source (output valid, output out_byte, output byte_valid, output item_end,
                  output batch_end, output stream_done, output run_empty, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input item_end,
                  input batch_end, input stream_done, input run_empty, output ready);
endinterface

// Configuration write channel.
interface qas_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [qas_pkg::CFG_IDX_W-1:0]   index;
  logic [qas_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/quoted_argument_splitter.sv -----
// Quoted argument splitter: byte tokenizer with batch grouping, top level.
// The block takes one byte transaction per clock while its skid register is empty
// and returns exactly one result transaction for each from a registered output.
// Parser phase, item length, batch count and running batch length are updated in
// the same cycle as the byte is taken, so the loop through that state sets the
// rate at one byte per cycle; a two-entry output buffer (head and skid register)
// keeps one more byte accepted after the result side stalls. Configuration writes
// are always accepted and must only happen while the block is idle. There is no
// clearing pass after reset and no memory.
`default_nettype none
`include "quoted_argument_splitter_defines.svh"
module quoted_argument_splitter #(
  parameter int ITEM_BUFFER_BYTES = 65536,
  parameter int MAX_BATCH_ITEMS   = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  qas_cfg_if.sink          cfg,
  qas_byte_if.sink         bytes,
  qas_token_if.source      tokens
);

  localparam int ILEN_W = $clog2(ITEM_BUFFER_BYTES);
  localparam int CNT_W  = $clog2(MAX_BATCH_ITEMS + 1);
  localparam int CMP_W  = qas_pkg::ARGS_W + 1;
  localparam int SUM_W  = qas_pkg::LEN_W + 1;

  typedef enum logic [2:0] {
    PH_SKIP  = 3'd0,
    PH_WORD  = 3'd1,
    PH_ESC   = 3'd2,
    PH_SQ    = 3'd3,
    PH_DQ    = 3'd4,
    PH_DQESC = 3'd5
  } phase_t;

  // Configuration registers.
  logic                         delimiter_mode;
  logic [qas_pkg::BYTE_W-1:0]   delimiter_char;
  logic [qas_pkg::ARGS_W-1:0]   max_args_per_batch;
  logic [qas_pkg::LEN_W-1:0]    base_length;
  logic [qas_pkg::LEN_W-1:0]    length_limit;
  logic                         no_run_when_empty;

  // Parser state.
  phase_t                       parse_phase, parse_phase_next;
  logic [ILEN_W-1:0]            item_length;
  logic [CNT_W-1:0]             batch_item_count;
  logic [qas_pkg::LEN_W-1:0]    batch_length;
  logic                         any_item_seen;

  // Output buffer: head register and skid register.
  logic                         out_valid, skid_valid;
  qas_pkg::result_t             out_data, skid_data, res;

  logic                         accept;
  logic [qas_pkg::BYTE_W-1:0]   c;
  logic                         eoi;
  logic                         is_space;
  logic                         do_store_req, do_close;
  logic                         unq_store, unq_close;
  phase_t                       unq_phase;
  logic                         can_store, do_store;
  logic                         pending;

  logic [SUM_W-1:0]             len_ext, total_ext, sum_ext;
  logic [qas_pkg::LEN_W-1:0]    total_sat;
  logic                         len_end, close_end;
  logic [CNT_W-1:0]             count_inc;

  assign cfg.ready    = 1'b1;
  assign bytes.ready  = !skid_valid;
  assign accept       = bytes.valid && bytes.ready;
  assign c            = bytes.in_byte;
  assign eoi          = bytes.end_of_input;

  assign is_space = (c == qas_pkg::CH_SPACE) || (c == qas_pkg::CH_TAB) ||
                    (c == qas_pkg::CH_NEWLINE);

  // Handling of a byte outside of quotes.
  always_comb begin
    unq_store = 1'b0;
    unq_close = 1'b0;
    unq_phase = PH_WORD;
    if (is_space) begin
      unq_close = 1'b1;
      unq_phase = PH_SKIP;
    end else if (c == qas_pkg::CH_BSLASH) begin
      unq_phase = PH_ESC;
    end else if (c == qas_pkg::CH_SQUOTE) begin
      unq_phase = PH_SQ;
    end else if (c == qas_pkg::CH_DQUOTE) begin
      unq_phase = PH_DQ;
    end else begin
      unq_store = 1'b1;
    end
  end

  // Byte classification by mode and phase.
  always_comb begin
    do_store_req     = 1'b0;
    do_close         = 1'b0;
    parse_phase_next = parse_phase;
    if (delimiter_mode) begin
      if (c == delimiter_char) do_close = 1'b1;
      else                     do_store_req = 1'b1;
    end else begin
      case (parse_phase)
        PH_WORD: begin
          do_store_req     = unq_store;
          do_close         = unq_close;
          parse_phase_next = unq_phase;
        end
        PH_ESC: begin
          do_store_req     = 1'b1;
          parse_phase_next = PH_WORD;
        end
        PH_SQ: begin
          if (c == qas_pkg::CH_SQUOTE) parse_phase_next = PH_WORD;
          else                         do_store_req = 1'b1;
        end
        PH_DQ: begin
          if (c == qas_pkg::CH_DQUOTE)      parse_phase_next = PH_WORD;
          else if (c == qas_pkg::CH_BSLASH) parse_phase_next = PH_DQESC;
          else                              do_store_req = 1'b1;
        end
        PH_DQESC: begin
          do_store_req     = 1'b1;
          parse_phase_next = PH_DQ;
        end
        default: begin
          if (is_space) begin
            parse_phase_next = PH_SKIP;
          end else begin
            do_store_req     = unq_store;
            do_close         = unq_close;
            parse_phase_next = unq_phase;
          end
        end
      endcase
    end
  end

  // Bytes beyond the item buffer are dropped.
  assign can_store = ({1'b0, item_length} + 1'b1) < (ILEN_W + 1)'(ITEM_BUFFER_BYTES);
  assign do_store  = do_store_req && can_store;

  // Item close: running length check, count limits.
  assign len_ext   = SUM_W'(item_length) + 1'b1;
  assign total_ext = (batch_item_count == '0) ? SUM_W'(base_length) : SUM_W'(batch_length);
  assign sum_ext   = total_ext + len_ext;
  assign len_end   = (batch_item_count != '0) && (sum_ext > SUM_W'(length_limit));
  assign total_sat = (sum_ext > SUM_W'(qas_pkg::LEN_MAX)) ? qas_pkg::LEN_MAX
                                                          : sum_ext[qas_pkg::LEN_W-1:0];
  assign count_inc = batch_item_count + 1'b1;
  assign close_end = len_end ||
                     ((max_args_per_batch != '0) &&
                      (CMP_W'(count_inc) >= CMP_W'(max_args_per_batch))) ||
                     (count_inc >= CNT_W'(MAX_BATCH_ITEMS));

  // End of input closes an item that holds stored bytes.
  assign pending = (delimiter_mode || (parse_phase != PH_SKIP)) && (item_length != '0);

  // Result of the accepted transaction.
  always_comb begin
    res = '0;
    if (eoi) begin
      res.item_end    = pending;
      res.batch_end   = pending || (batch_item_count != '0);
      res.stream_done = 1'b1;
      res.run_empty   = !(any_item_seen || pending) && !no_run_when_empty;
    end else begin
      res.out_byte   = do_store ? c : '0;
      res.byte_valid = do_store;
      res.item_end   = do_close;
      res.batch_end  = do_close && close_end;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_mode     <= 1'b0;
      delimiter_char     <= qas_pkg::DELIM_RESET;
      max_args_per_batch <= '0;
      base_length        <= '0;
      length_limit       <= qas_pkg::LIMIT_RESET;
      no_run_when_empty  <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        qas_pkg::REG_DELIMITER_MODE:     delimiter_mode     <= cfg.data[0];
        qas_pkg::REG_DELIMITER_CHAR:     delimiter_char     <= cfg.data[qas_pkg::BYTE_W-1:0];
        qas_pkg::REG_MAX_ARGS_PER_BATCH: max_args_per_batch <= cfg.data[qas_pkg::ARGS_W-1:0];
        qas_pkg::REG_BASE_LENGTH:        base_length        <= cfg.data[qas_pkg::LEN_W-1:0];
        qas_pkg::REG_LENGTH_LIMIT:       length_limit       <= cfg.data[qas_pkg::LEN_W-1:0];
        qas_pkg::REG_NO_RUN_WHEN_EMPTY:  no_run_when_empty  <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Parser state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase      <= PH_SKIP;
      item_length      <= '0;
      batch_item_count <= '0;
      batch_length     <= '0;
      any_item_seen    <= 1'b0;
    end else if (accept) begin
      if (eoi) begin
        parse_phase      <= PH_SKIP;
        item_length      <= '0;
        batch_item_count <= '0;
        batch_length     <= '0;
        any_item_seen    <= 1'b0;
      end else begin
        if (!delimiter_mode) parse_phase <= parse_phase_next;
        if (do_store) item_length <= item_length + 1'b1;
        if (do_close) begin
          item_length   <= '0;
          any_item_seen <= 1'b1;
          if (close_end) begin
            batch_item_count <= '0;
            batch_length     <= '0;
          end else begin
            batch_item_count <= count_inc;
            batch_length     <= len_end ? total_ext[qas_pkg::LEN_W-1:0] : total_sat;
          end
        end
      end
    end
  end

  // Output buffer with skid register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !tokens.ready) begin
      if (accept) begin
        skid_valid <= 1'b1;
        skid_data  <= res;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      out_data   <= skid_data;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= accept;
      out_data  <= res;
    end
  end

  assign tokens.valid       = out_valid;
  assign tokens.out_byte    = out_data.out_byte;
  assign tokens.byte_valid  = out_data.byte_valid;
  assign tokens.item_end    = out_data.item_end;
  assign tokens.batch_end   = out_data.batch_end;
  assign tokens.stream_done = out_data.stream_done;
  assign tokens.run_empty   = out_data.run_empty;

  // The skid register is only filled behind an occupied head.
  `QAS_ASSERT_NOW(a_skid_behind_head, clk, rst, skid_valid, out_valid)
  // The batch count never rests at MAX_BATCH_ITEMS.
  `QAS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, batch_item_count < CNT_W'(MAX_BATCH_ITEMS))
  // End of input leaves the parser in its reset state.
  `QAS_ASSERT_NEXT(a_eoi_clears, clk, rst, accept && eoi,
                   (parse_phase == PH_SKIP) && (item_length == '0) && (batch_item_count == '0))
  // A batch only ends with an item end or with the end of the stream.
  `QAS_ASSERT_NOW(a_batch_end_cause, clk, rst, out_valid && out_data.batch_end,
                  out_data.item_end || out_data.stream_done)

endmodule
`default_nettype wire
